>>> design/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// shared types, round constants and sigma functions for the sha-256 hasher
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } state_e;

  localparam logic       KIND_BYTE   = 1'b0;
  localparam logic       KIND_FINISH = 1'b1;
  localparam logic [7:0] PAD_MARKER  = 8'h80;
  localparam logic [5:0] LEN_START   = 6'd56;
  localparam logic [5:0] LAST_POS    = 6'd63;
  localparam logic [5:0] LAST_ROUND  = 6'd63;
  localparam logic [2:0] LAST_WORD   = 3'd7;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

>>> design/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// byte-serial sha-256 hasher with a single iterative round unit
// ----------------------------------------------------------------------------
// usage
//   slave channel: one beat per message byte (tuser = 0, byte in tdata), or a
//   finish beat (tuser = 1) that closes the message and starts the digest.
//   master channel: eight beats per finish, digest word 0 first, word in
//   tdata[31:0], its index in tdata[34:32], tlast on the eighth word.
// timing
//   a byte that does not complete a block leaves the block idle and ready for
//   the next byte. the byte that fills the 64-byte block is followed by the
//   rounds and a feed-forward update; the single round unit (one round a
//   cycle) sets the cost of a block. a finish beat at buffer position p is
//   followed by padding of positions p + 1 to 63, the rounds and the update,
//   and one more 64-byte pad block with rounds and update when p >= 56;
//   then the eight digest beats follow, one a cycle while the sink is ready.
// reset and stalls
//   reset loads the initial hash words and clears the byte count. tready is
//   low from a block-filling or finish beat until the block work and, for a
//   finish, the eight digest beats are out; a stalled sink simply holds the digest
//   beat and the block idles. after the last digest beat the chaining value
//   and the count return to their initial values for the next message.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] kind
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        m_axis_tlast_o    // last_word
);

  state_e state_q, state_d;

  logic [60:0] cnt_q, cnt_d;          // message length in bytes, wraps
  logic [31:0] h_q [8];               // chaining value
  logic [31:0] h_d [8];
  logic [31:0] v_q [8];               // working variables a..h
  logic [31:0] v_d [8];
  logic [31:0] w_q [16];              // block words, then schedule window
  logic [31:0] w_d [16];
  logic [5:0]  rnd_q, rnd_d;
  logic [5:0]  pad_idx_q, pad_idx_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic        fin_q, fin_d;          // block under compression closes the message
  logic        two_q, two_d;          // length spills into an extra pad block

  logic [5:0]  pos;
  logic [63:0] bit_len;
  logic        in_fire, out_fire;

  // byte write port into the block buffer
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_byte;

  // round unit
  logic [31:0] t1, t2, w_next;

  assign pos      = cnt_q[5:0];
  assign bit_len  = {cnt_q, 3'b000};
  assign in_fire  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o & m_axis_tready_i;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (pos == LAST_POS) begin
            state_d = ST_ROUND;
          end else if (s_axis_tuser_i == KIND_FINISH) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (pad_idx_q == LAST_POS) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_q == LAST_ROUND) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (two_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_fire && out_idx_q == LAST_WORD) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- fsm outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = pos;
    wr_byte         = s_axis_tdata_i;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        wr_en           = in_fire;
        wr_addr         = pos;
        wr_byte         = (s_axis_tuser_i == KIND_FINISH) ? PAD_MARKER : s_axis_tdata_i;
      end
      ST_PAD: begin
        wr_en   = 1'b1;
        wr_addr = pad_idx_q;
        if (!two_q && pad_idx_q >= LEN_START) begin
          // big-endian bit length in the last eight bytes
          wr_byte = bit_len[{~pad_idx_q[2:0], 3'b000} +: 8];
        end else begin
          wr_byte = 8'h00;
        end
      end
      ST_OUT: begin
        m_axis_tvalid_o = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign m_axis_tdata_o = {5'd0, out_idx_q, h_q[out_idx_q]};
  assign m_axis_tlast_o = (out_idx_q == LAST_WORD);

  // ---------------------------------------------------------------- round unit
  always_comb begin
    t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + ROUND_K[rnd_q] + w_q[0];
    t2 = big_sigma0(v_q[0])
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    w_next = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    cnt_d     = cnt_q;
    h_d       = h_q;
    v_d       = v_q;
    w_d       = w_q;
    rnd_d     = rnd_q;
    pad_idx_d = pad_idx_q;
    out_idx_d = out_idx_q;
    fin_d     = fin_q;
    two_d     = two_q;

    if (wr_en) begin
      w_d[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] = wr_byte;
    end

    case (state_q)
      ST_IDLE: begin
        v_d   = h_q;
        rnd_d = '0;
        if (in_fire) begin
          if (s_axis_tuser_i == KIND_BYTE) begin
            cnt_d = cnt_q + 61'd1;
          end else begin
            fin_d     = 1'b1;
            two_d     = (pos >= LEN_START);
            pad_idx_d = pos + 6'd1;
          end
        end
      end
      ST_PAD: begin
        v_d       = h_q;
        rnd_d     = '0;
        pad_idx_d = pad_idx_q + 6'd1;
      end
      ST_ROUND: begin
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[15] = w_next;
        rnd_d   = rnd_q + 6'd1;
      end
      ST_UPDATE: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        out_idx_d = '0;
        if (fin_q && two_q) begin
          two_d     = 1'b0;
          pad_idx_d = '0;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          out_idx_d = out_idx_q + 3'd1;
          if (out_idx_q == LAST_WORD) begin
            h_d   = INIT_HASH;
            cnt_d = '0;
            fin_d = 1'b0;
          end
        end
      end
      default: begin
        fin_d = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      h_q       <= INIT_HASH;
      rnd_q     <= '0;
      pad_idx_q <= '0;
      out_idx_q <= '0;
      fin_q     <= 1'b0;
      two_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      h_q       <= h_d;
      rnd_q     <= rnd_d;
      pad_idx_q <= pad_idx_d;
      out_idx_q <= out_idx_d;
      fin_q     <= fin_d;
      two_q     <= two_d;
    end
  end

  // working variables and block words need no reset
  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
  end

  // ---------------------------------------------------------------- assertions
  // input and output never open together
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("tready and digest tvalid both high");

  // tlast travels only with the eighth word
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tdata_o[34:32] == LAST_WORD))
    else $error("tlast on a word other than the last");

  // after the final digest beat the block takes input again, count cleared
  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && m_axis_tlast_o) |=> (s_axis_tready_o && cnt_q == '0))
    else $error("not idle with cleared count after digest");

  // a finish beat never leads straight back to input
  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tuser_i == KIND_FINISH) |=> !s_axis_tready_o)
    else $error("ready right after a finish beat");

endmodule
